@@ src/se_pkg.sv @@
// shared constants and types for the softmax entropy block
package se_pkg;

    // vector store depth and derived widths
    localparam int VOCAB_DEPTH = 32768;
    localparam int ADDR_W      = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(VOCAB_DEPTH + 1);
    localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(VOCAB_DEPTH);

    // fixed-point constants
    localparam logic [32:0] LOG2E_Q1_32 = 33'h1_7154_7653;
    localparam logic [31:0] LN2_Q0_32   = 32'hB172_17F8;
    localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;

    // store port request
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       wdata;
    } store_req_t;

endpackage

@@ src/softmax_entropy_top.sv @@
// Loading accepts one element per cycle; busy stays low while a vector streams in.
// After the last element: pass one runs the exp series unit on each stored element, pass
// two runs exp, the bit-serial divider and the log squaring loop on each element (the log
// step is skipped when p is zero); then a finishing state and the result strobe. The
// store has no reset or clearing pass; reset clears all vector and control state. The
// result is held on the ports until the next one; done is high for a single cycle.
module softmax_entropy_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] logit_value,
    input  logic        last_logit,
    output logic        done,
    output logic [15:0] entropy_nats,
    output logic        overflow_seen
);
    import se_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD, ST_RD, ST_RDW, ST_EXPW, ST_DIVW, ST_LOGW, ST_FIN
    } state_t;

    state_t             state_reg;
    logic               pass2_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] idx_reg;
    logic signed [15:0] max_reg;
    logic [47:0]        sum_reg;
    logic [39:0]        acc_reg;
    logic               ovf_reg;
    logic               done_reg;
    logic [15:0]        ent_reg;
    logic               ovf_out_reg;

    store_req_t         req;
    logic [15:0]        rdata;
    logic               accept;
    logic               room;
    logic signed [16:0] diff;
    logic               exp_start;
    logic               exp_done;
    logic [31:0]        e_val;
    logic               div_start;
    logic               div_done;
    logic [31:0]        p_val;
    logic               log_start;
    logic               log_done;
    logic [31:0]        term_val;
    logic [COUNT_W-1:0] idx_inc;
    logic               at_end;
    logic [40:0]        acc_sum;
    logic [39:0]        acc_sat;
    logic [40:0]        ent_rnd;
    logic [20:0]        ent_full;

    // input transaction and store port
    assign busy       = (state_reg != ST_LOAD);
    assign accept     = start && !busy;
    assign room       = (count_reg < DEPTH_CNT);
    assign req.we     = accept && room;
    assign req.re     = (state_reg == ST_RD);
    assign req.addr   = req.we ? count_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign req.wdata  = logit_value;

    se_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    // distance below the maximum, always in 0..65535
    assign diff      = {max_reg[15], max_reg} - {rdata[15], rdata};
    assign exp_start = (state_reg == ST_RDW);
    assign div_start = (state_reg == ST_EXPW) && exp_done && pass2_reg;
    assign log_start = (state_reg == ST_DIVW) && div_done && (p_val != 32'd0);

    se_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (exp_start),
        .k     (diff[15:0]),
        .done  (exp_done),
        .e     (e_val)
    );

    se_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .e     (e_val),
        .sum   (sum_reg),
        .done  (div_done),
        .p     (p_val)
    );

    se_log u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .start (log_start),
        .p     (p_val),
        .done  (log_done),
        .term  (term_val)
    );

    // element walk and saturating accumulate
    assign idx_inc  = idx_reg + 1'b1;
    assign at_end   = (idx_inc == count_reg);
    assign acc_sum  = {1'b0, acc_reg} + {9'b0, term_val};
    assign acc_sat  = acc_sum[40] ? '1 : acc_sum[39:0];
    assign ent_rnd  = {1'b0, acc_reg} + 41'h0_0008_0000;
    assign ent_full = ent_rnd[40:20];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            pass2_reg   <= 1'b0;
            count_reg   <= '0;
            idx_reg     <= '0;
            max_reg     <= '0;
            sum_reg     <= '0;
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            done_reg    <= 1'b0;
            ent_reg     <= '0;
            ovf_out_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (room)
                        begin
                            if ((count_reg == '0) || ($signed(logit_value) > max_reg))
                            begin
                                max_reg <= logit_value;
                            end
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (last_logit)
                        begin
                            idx_reg   <= '0;
                            pass2_reg <= 1'b0;
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_RDW;
                end
                ST_RDW:
                begin
                    state_reg <= ST_EXPW;
                end
                ST_EXPW:
                begin
                    if (exp_done)
                    begin
                        if (pass2_reg)
                        begin
                            state_reg <= ST_DIVW;
                        end
                        else
                        begin
                            sum_reg <= sum_reg + {16'b0, e_val};
                            idx_reg <= at_end ? '0 : idx_inc;
                            pass2_reg <= at_end;
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_DIVW:
                begin
                    if (div_done)
                    begin
                        if (p_val != 32'd0)
                        begin
                            state_reg <= ST_LOGW;
                        end
                        else
                        begin
                            idx_reg   <= idx_inc;
                            state_reg <= at_end ? ST_FIN : ST_RD;
                        end
                    end
                end
                ST_LOGW:
                begin
                    if (log_done)
                    begin
                        acc_reg   <= acc_sat;
                        idx_reg   <= idx_inc;
                        state_reg <= at_end ? ST_FIN : ST_RD;
                    end
                end
                ST_FIN:
                begin
                    ent_reg     <= (ent_full[20:16] != 5'b0) ? 16'hFFFF : ent_full[15:0];
                    ovf_out_reg <= ovf_reg;
                    done_reg    <= 1'b1;
                    count_reg   <= '0;
                    idx_reg     <= '0;
                    max_reg     <= '0;
                    sum_reg     <= '0;
                    acc_reg     <= '0;
                    ovf_reg     <= 1'b0;
                    pass2_reg   <= 1'b0;
                    state_reg   <= ST_LOAD;
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign entropy_nats  = ent_reg;
    assign overflow_seen = ovf_out_reg;

`ifndef NO_ASSERTIONS
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FIN))
        else $error("result strobe without a finished vector");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("element count beyond store depth");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (idx_reg < count_reg))
        else $error("store read past the loaded elements");

    a_sum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD && pass2_reg) |-> (sum_reg != '0))
        else $error("entropy pass with zero exp sum");
`endif

endmodule

@@ src/se_store.sv @@
// logit store: single-port synchronous memory with a registered read
module se_store (
    input  logic              clk,
    input  se_pkg::store_req_t req,
    output logic [15:0]       rdata
);
    import se_pkg::*;

    logic [15:0] mem [VOCAB_DEPTH];

    // write on load, registered read during the passes
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.addr];
        end
    end

endmodule

@@ src/se_exp.sv @@
// exp(-k/256) unit: log2e scaling, then a 12-term series, each term a multiply, divide and fix-up step
module se_exp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] k,
    output logic        done,
    output logic [31:0] e
);
    import se_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_Y, ST_MUL_Z, ST_T_MUL, ST_T_DIV, ST_T_FIX, ST_FINAL
    } state_t;

    // floor(2^33 / n) for the series divisors
    function automatic logic [33:0] recip_q33(input logic [3:0] n);
        logic [33:0] r;
        case (n)
            4'd1:    r = 34'h2_0000_0000;
            4'd2:    r = 34'h1_0000_0000;
            4'd3:    r = 34'h0_AAAA_AAAA;
            4'd4:    r = 34'h0_8000_0000;
            4'd5:    r = 34'h0_6666_6666;
            4'd6:    r = 34'h0_5555_5555;
            4'd7:    r = 34'h0_4924_9249;
            4'd8:    r = 34'h0_4000_0000;
            4'd9:    r = 34'h0_38E3_8E38;
            4'd10:   r = 34'h0_3333_3333;
            4'd11:   r = 34'h0_2E8B_A2E8;
            4'd12:   r = 34'h0_2AAA_AAAA;
            default: r = '0;
        endcase
        return r;
    endfunction

    state_t      state_reg;
    logic [15:0] k_reg;
    logic [8:0]  i_reg;
    logic [31:0] f_reg;
    logic [31:0] z_reg;
    logic [32:0] term_reg;
    logic [33:0] acc_reg;
    logic [31:0] prod_reg;
    logic [31:0] qest_reg;
    logic [3:0]  n_reg;
    logic        done_reg;
    logic [31:0] e_reg;

    logic [48:0] y_full;
    logic [63:0] z_full;
    logic [64:0] tz_full;
    logic [65:0] qd_full;
    logic [35:0] qn;
    logic [35:0] rem;
    logic [31:0] q_fixed;
    logic [34:0] rnd_sum;
    logic [34:0] rnd_add;
    logic [34:0] shifted;

    // datapath products
    assign y_full  = {16'b0, k_reg} * {16'b0, LOG2E_Q1_32};
    assign z_full  = f_reg * LN2_Q0_32;
    assign tz_full = term_reg * {1'b0, z_reg};
    assign qd_full = prod_reg * recip_q33(n_reg);
    assign qn      = qest_reg * n_reg;
    assign rem     = {4'b0, prod_reg} - qn;
    assign q_fixed = (rem >= {32'b0, n_reg}) ? qest_reg + 32'd1 : qest_reg;

    // final rounding shift by the integer part
    assign rnd_add = (i_reg == 9'd0) ? 35'd0 : (35'd1 << (i_reg[5:0] - 6'd1));
    assign rnd_sum = {1'b0, acc_reg} + rnd_add;
    assign shifted = rnd_sum >> i_reg[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            f_reg     <= '0;
            z_reg     <= '0;
            term_reg  <= '0;
            acc_reg   <= '0;
            prod_reg  <= '0;
            qest_reg  <= '0;
            n_reg     <= '0;
            done_reg  <= 1'b0;
            e_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        k_reg     <= k;
                        state_reg <= ST_MUL_Y;
                    end
                end
                ST_MUL_Y:
                begin
                    i_reg     <= y_full[48:40];
                    f_reg     <= y_full[39:8];
                    state_reg <= ST_MUL_Z;
                end
                ST_MUL_Z:
                begin
                    z_reg     <= z_full[63:32];
                    term_reg  <= ONE_Q32;
                    acc_reg   <= {1'b0, ONE_Q32};
                    n_reg     <= 4'd1;
                    state_reg <= ST_T_MUL;
                end
                ST_T_MUL:
                begin
                    prod_reg  <= tz_full[63:32];
                    state_reg <= ST_T_DIV;
                end
                ST_T_DIV:
                begin
                    qest_reg  <= qd_full[64:33];
                    state_reg <= ST_T_FIX;
                end
                ST_T_FIX:
                begin
                    term_reg <= {1'b0, q_fixed};
                    // odd terms subtract with floor at zero, even terms add
                    if (n_reg[0])
                    begin
                        acc_reg <= ({2'b0, q_fixed} > acc_reg) ? '0
                                 : acc_reg - {2'b0, q_fixed};
                    end
                    else
                    begin
                        acc_reg <= acc_reg + {2'b0, q_fixed};
                    end
                    n_reg <= n_reg + 4'd1;
                    if (n_reg == 4'd12)
                    begin
                        state_reg <= ST_FINAL;
                    end
                    else
                    begin
                        state_reg <= ST_T_MUL;
                    end
                end
                ST_FINAL:
                begin
                    if (i_reg > 9'd32)
                    begin
                        e_reg <= '0;
                    end
                    else if (shifted[34:32] != 3'b0)
                    begin
                        e_reg <= '1;
                    end
                    else
                    begin
                        e_reg <= shifted[31:0];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign e    = e_reg;

endmodule

@@ src/se_div.sv @@
// p = floor(e * 2^32 / sum) saturated to all ones, restoring division one quotient bit per cycle
module se_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] e,
    input  logic [47:0] sum,
    output logic        done,
    output logic [31:0] p
);
    import se_pkg::*;

    typedef enum logic [0:0] {ST_IDLE, ST_RUN} state_t;

    state_t      state_reg;
    logic [47:0] rem_reg;
    logic [47:0] sum_reg;
    logic [31:0] q_reg;
    logic        qtop_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [31:0] p_reg;

    logic [48:0] rem2;
    logic        ge;
    logic [31:0] q_next;

    // one restoring step
    assign rem2   = {rem_reg, 1'b0};
    assign ge     = rem2 >= {1'b0, sum_reg};
    assign q_next = {q_reg[30:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rem_reg   <= '0;
            sum_reg   <= '0;
            q_reg     <= '0;
            qtop_reg  <= 1'b0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            p_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        sum_reg <= sum;
                        q_reg   <= '0;
                        cnt_reg <= 6'd32;
                        // integer bit of the quotient
                        if ({16'b0, e} >= sum)
                        begin
                            qtop_reg <= 1'b1;
                            rem_reg  <= {16'b0, e} - sum;
                        end
                        else
                        begin
                            qtop_reg <= 1'b0;
                            rem_reg  <= {16'b0, e};
                        end
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    rem_reg <= ge ? (rem2[47:0] - sum_reg) : rem2[47:0];
                    q_reg   <= q_next;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        p_reg     <= qtop_reg ? 32'hFFFF_FFFF : q_next;
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

@@ src/se_log.sv @@
// -p*ln(p) term: normalize, 32 squaring steps for log2, then two scaling products
module se_log (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] p,
    output logic        done,
    output logic [31:0] term
);
    import se_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_NORM, ST_SQR, ST_NL, ST_MUL1, ST_MUL2} state_t;

    state_t      state_reg;
    logic [31:0] p_reg;
    logic [31:0] m_reg;
    logic [4:0]  b_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] frac_reg;
    logic [37:0] nl_reg;
    logic [32:0] t1_reg;
    logic        done_reg;
    logic [31:0] term_reg;

    logic [63:0] sq_full;
    logic [32:0] sq;
    logic [61:0] pm_full;
    logic [64:0] tm_full;

    assign sq_full = m_reg * m_reg;
    assign sq      = sq_full[63:31];
    assign pm_full = p_reg * nl_reg[37:8];
    assign tm_full = t1_reg * {1'b0, LN2_Q0_32};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            p_reg     <= '0;
            m_reg     <= '0;
            b_reg     <= '0;
            cnt_reg   <= '0;
            frac_reg  <= '0;
            nl_reg    <= '0;
            t1_reg    <= '0;
            done_reg  <= 1'b0;
            term_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        p_reg     <= p;
                        m_reg     <= p;
                        b_reg     <= 5'd31;
                        state_reg <= ST_NORM;
                    end
                end
                // shift left until the top bit is set, tracking the msb index
                ST_NORM:
                begin
                    if (m_reg[31] || (b_reg == 5'd0))
                    begin
                        cnt_reg   <= '0;
                        frac_reg  <= '0;
                        state_reg <= ST_SQR;
                    end
                    else
                    begin
                        m_reg <= {m_reg[30:0], 1'b0};
                        b_reg <= b_reg - 5'd1;
                    end
                end
                // one fraction bit of log2 per squaring
                ST_SQR:
                begin
                    if (sq[32])
                    begin
                        m_reg    <= sq[32:1];
                        frac_reg <= {frac_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        m_reg    <= sq[31:0];
                        frac_reg <= {frac_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= ST_NL;
                    end
                end
                ST_NL:
                begin
                    nl_reg    <= {6'd32 - {1'b0, b_reg}, 32'b0} - {6'b0, frac_reg};
                    state_reg <= ST_MUL1;
                end
                ST_MUL1:
                begin
                    t1_reg    <= pm_full[56:24];
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    term_reg  <= tm_full[63:32];
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign term = term_reg;

endmodule

@@ tb/tb_softmax_entropy_top.sv @@
// self-checking testbench for the softmax entropy block
module tb_softmax_entropy_top;
    timeunit 1ns;
    timeprecision 1ps;

    import se_pkg::*;

    localparam int WATCHDOG_LIMIT = 30_000_000;
    localparam int DRAIN_CYCLES   = 400;

    typedef struct {
        logic [15:0] logit;
        logic        last;
    } logit_txn_t;

    typedef struct {
        logic [15:0] ent;
        logic        ovf;
    } entropy_txn_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] logit_value;
    logic        last_logit;
    logic        done;
    logic [15:0] entropy_nats;
    logic        overflow_seen;

    logit_txn_t   pending_q[$];
    entropy_txn_t entropy_q[$];
    logic [15:0]  vec_logits[$];
    logic         vec_dropped;
    int           fail_cnt;
    int           idle_pct;
    int           stall_cycles;
    bit           took_last;

    softmax_entropy_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .logit_value   (logit_value),
        .last_logit    (last_logit),
        .done          (done),
        .entropy_nats  (entropy_nats),
        .overflow_seen (overflow_seen)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_cnt++;
    endtask

    // exp(-k/256) in Q0.32 via 2^-(i+f) and a truncated Taylor series
    function automatic logic [63:0] exp_neg_q32(input logic [63:0] k);
        logic [63:0] log2e;
        logic [63:0] y;
        logic [63:0] i;
        logic [63:0] f;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] r;
        log2e = 64'(LOG2E_Q1_32);
        y     = k * log2e;
        i     = y >> 40;
        f     = y & 64'hFF_FFFF_FFFF;
        z     = ((f >> 8) * 64'(LN2_Q0_32)) >> 32;
        term  = 64'(ONE_Q32);
        acc   = 64'(ONE_Q32);
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * z) >> 32) / 64'(n);
            if (n % 2 == 1)
                acc = (term > acc) ? 64'd0 : acc - term;
            else
                acc = acc + term;
        end
        if (i > 32)
            return 64'd0;
        if (i == 0)
            r = acc;
        else
            r = (acc + (64'd1 << (i - 1))) >> i;
        return (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
    endfunction

    // -p*ln(p) in Q0.32 using a squaring log2
    function automatic logic [63:0] neg_plogp_q32(input logic [63:0] p);
        int          msb;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] neglog2;
        logic [63:0] t1;
        msb  = 0;
        frac = 64'd0;
        for (int s = 0; s < 32; s++)
            if (p[s])
                msb = s;
        m = p << (31 - msb);
        for (int s = 0; s < 32; s++)
        begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'(ONE_Q32))
            begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        neglog2 = (64'(32 - msb) << 32) - frac;
        t1      = (p * (neglog2 >> 8)) >> 24;
        return (t1 * 64'(LN2_Q0_32)) >> 32;
    endfunction

    // entropy of the vector held so far
    function automatic entropy_txn_t vector_entropy();
        int           vmax;
        logic [63:0]  esum;
        logic [63:0]  eacc;
        logic [63:0]  e;
        logic [63:0]  p;
        logic [63:0]  ent;
        entropy_txn_t res;
        vmax = $signed(vec_logits[0]);
        foreach (vec_logits[j])
            if ($signed(vec_logits[j]) > vmax)
                vmax = $signed(vec_logits[j]);
        esum = 64'd0;
        foreach (vec_logits[j])
            esum = esum + exp_neg_q32(64'(vmax - int'($signed(vec_logits[j]))));
        eacc = 64'd0;
        foreach (vec_logits[j])
        begin
            e = exp_neg_q32(64'(vmax - int'($signed(vec_logits[j]))));
            p = (e << 32) / esum;
            if (p > 64'hFFFF_FFFF)
                p = 64'hFFFF_FFFF;
            if (p != 0)
            begin
                eacc = eacc + neg_plogp_q32(p);
                if (eacc > 64'hFF_FFFF_FFFF)
                    eacc = 64'hFF_FFFF_FFFF;
            end
        end
        ent = (eacc + (64'd1 << 19)) >> 20;
        if (ent > 64'hFFFF)
            ent = 64'hFFFF;
        res.ent = ent[15:0];
        res.ovf = vec_dropped;
        return res;
    endfunction

    // accept transactions, predict, check results, watchdog
    always @(posedge clk)
    begin
        logit_txn_t   txn;
        entropy_txn_t want;
        took_last = 1'b0;
        if (rst_n)
        begin
            stall_cycles++;
            if (start && !busy)
            begin
                took_last    = 1'b1;
                stall_cycles = 0;
                txn = pending_q.pop_front();
                if (vec_logits.size() < VOCAB_DEPTH)
                    vec_logits.push_back(txn.logit);
                else
                    vec_dropped = 1'b1;
                if (txn.last)
                begin
                    entropy_q.push_back(vector_entropy());
                    vec_logits.delete();
                    vec_dropped = 1'b0;
                end
            end
            if (done)
            begin
                stall_cycles = 0;
                if (entropy_q.size() == 0)
                    report_mismatch("result with no vector pending");
                else
                begin
                    want = entropy_q.pop_front();
                    if (entropy_nats !== want.ent)
                        report_mismatch($sformatf("entropy_nats got %0h want %0h",
                                                  entropy_nats, want.ent));
                    if (overflow_seen !== want.ovf)
                        report_mismatch($sformatf("overflow_seen got %0b want %0b",
                                                  overflow_seen, want.ovf));
                end
            end
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // driver: hold start until accepted, idle at random otherwise
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !took_last)
            start <= 1'b1;
        else if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            start       <= 1'b1;
            logit_value <= pending_q[0].logit;
            last_logit  <= pending_q[0].last;
        end
        else
            start <= 1'b0;
    end

    task automatic push_logit(input logic [15:0] v, input logic last);
        logit_txn_t t;
        t.logit = v;
        t.last  = last;
        pending_q.push_back(t);
    endtask

    // one random vector; returns its length
    task automatic push_random_vector(output int len);
        int mode;
        int base;
        int spread;
        mode = $urandom_range(99);
        if (mode < 70)
            len = $urandom_range(6, 1);
        else if (mode < 95)
            len = $urandom_range(40, 7);
        else
            len = $urandom_range(200, 41);
        base   = $urandom_range(65535) - 32768;
        spread = 1 << $urandom_range(16);
        mode   = $urandom_range(3);
        for (int j = 0; j < len; j++)
        begin
            if (mode == 0)
                push_logit(16'($urandom), j == len - 1);
            else
                push_logit(16'(base + int'($urandom_range(spread - 1))), j == len - 1);
        end
    endtask

    // wait until the queue is drained and every result has come
    task automatic wait_quiet();
        wait (pending_q.size() == 0 && !start);
        wait (entropy_q.size() == 0);
        @(negedge clk);
    endtask

    task automatic random_phase(input int pct, input int items);
        int cnt;
        int len;
        idle_pct = pct;
        cnt = 0;
        while (cnt < items)
        begin
            push_random_vector(len);
            cnt += len;
        end
        wait_quiet();
    endtask

    // stimulus
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        logit_value  = 16'd0;
        last_logit   = 1'b0;
        fail_cnt     = 0;
        idle_pct     = 0;
        stall_cycles = 0;
        vec_dropped  = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, single element, widest gap, equal logits, tiny terms
        push_logit(16'h8000, 1'b1);
        push_logit(16'h7FFF, 1'b1);
        push_logit(16'h7FFF, 1'b0);
        push_logit(16'h8000, 1'b1);
        for (int j = 0; j < 4; j++)
            push_logit(16'h0000, j == 3);
        push_logit(16'h0100, 1'b0);
        push_logit(16'h0000, 1'b0);
        push_logit(16'hFFFF, 1'b0);
        push_logit(16'hE000, 1'b0);
        push_logit(16'h1800, 1'b1);
        push_logit(16'h5555, 1'b0);
        push_logit(16'hAAAA, 1'b0);
        push_logit(16'h5554, 1'b1);
        for (int j = 0; j < 6; j++)
            push_logit(16'(j * 16'h0280), j == 5);
        wait_quiet();

        // store full: the extra elements are dropped, last one still closes
        for (int j = 0; j < VOCAB_DEPTH + 2; j++)
            push_logit(16'($urandom_range(4095)), j == VOCAB_DEPTH + 1);
        wait_quiet();

        random_phase(0, 500);
        random_phase(82, 450);
        random_phase(27, 450);
        random_phase(0, 450);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/se_pkg.sv
src/se_store.sv
src/se_exp.sv
src/se_div.sv
src/se_log.sv
src/softmax_entropy_top.sv
tb/tb_softmax_entropy_top.sv
